/* design/sat_pkg.sv */
// Shared types and codes for the sorted array table unit.
// Holds operation and status codes, controller commands and datapath status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  // Request operation codes carried in s_tuser.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Result status codes carried in m_tuser.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // Table read address selects.
  localparam logic [2:0] RD_CNT_M1   = 3'd0;
  localparam logic [2:0] RD_IDX_M1   = 3'd1;
  localparam logic [2:0] RD_MID_CALC = 3'd2;
  localparam logic [2:0] RD_MID_P1   = 3'd3;
  localparam logic [2:0] RD_IDX_P2   = 3'd4;

  // Table write selects.
  localparam logic [1:0] WR_UP_DATA  = 2'd0;  // table[idx+1] <= read data
  localparam logic [1:0] WR_UP_KEY   = 2'd1;  // table[idx+1] <= key
  localparam logic [1:0] WR_AT_DATA  = 2'd2;  // table[idx]   <= read data

  // Index register updates.
  localparam logic [2:0] IDX_HOLD   = 3'd0;
  localparam logic [2:0] IDX_CNT_M1 = 3'd1;
  localparam logic [2:0] IDX_DEC    = 3'd2;
  localparam logic [2:0] IDX_INC    = 3'd3;
  localparam logic [2:0] IDX_MID    = 3'd4;

  // Result position selects.
  localparam logic [1:0] POS_ZERO   = 2'd0;
  localparam logic [1:0] POS_IDX_P1 = 2'd1;
  localparam logic [1:0] POS_MID    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [2:0] idx_op;
    logic       bs_init;
    logic       bs_lo;
    logic       bs_hi;
    logic       mid_load;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_load;
    logic [1:0] res_status;
    logic [1:0] res_pos_sel;
    logic       push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       key_lt;
    logic       key_eq;
    logic       idx_zero;
    logic       lo_gt_hi;
    logic       mid_last;
    logic       shift_last;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/sat_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/sat_datapath.sv */
// Datapath of the sorted array table: key table memory, count, search
// bounds, shift index, result and output registers. Uses sat_pkg and sat_ram.
`timescale 1ns / 1ps
`default_nettype none

module sat_datapath
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_WIDTH   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic [1:0]            in_func,
  input  wire logic [KEY_WIDTH-1:0]  in_key,
  input  wire logic                  m_tready,
  output logic                       m_tvalid,
  output logic [1:0]                 m_status,
  output logic [$clog2(TABLE_DEPTH)-1:0]   m_position,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] m_count
);

  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = CW + 1;

  logic [1:0]           func;
  logic [KEY_WIDTH-1:0] key;
  logic [CW-1:0]        count;
  logic signed [IW-1:0] lo;
  logic signed [IW-1:0] hi;
  logic signed [IW-1:0] idx;
  logic [PW-1:0]        mid;
  logic [1:0]           res_status;
  logic [PW-1:0]        res_pos;

  logic signed [IW-1:0] cnt_s;
  logic signed [IW-1:0] cnt_m1;
  logic signed [IW-1:0] idx_m1;
  logic signed [IW-1:0] idx_p1;
  logic signed [IW-1:0] idx_p2;
  logic signed [IW-1:0] mid_s;
  logic signed [IW:0]   bound_sum;
  logic [PW-1:0]        mid_calc;
  logic [PW-1:0]        mid_p1;

  logic                 rd_en;
  logic [PW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [PW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  // Index arithmetic shared by the search and shift loops.
  assign cnt_s     = IW'(count);
  assign cnt_m1    = cnt_s - IW'(1);
  assign idx_m1    = idx - IW'(1);
  assign idx_p1    = idx + IW'(1);
  assign idx_p2    = idx + IW'(2);
  assign mid_s     = IW'(mid);
  assign bound_sum = (IW+1)'(lo) + (IW+1)'(hi);
  assign mid_calc  = bound_sum[PW:1];
  assign mid_p1    = mid + PW'(1);

  // Read address selection.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_CNT_M1:   rd_addr = cnt_m1[PW-1:0];
      RD_IDX_M1:   rd_addr = idx_m1[PW-1:0];
      RD_MID_CALC: rd_addr = mid_calc;
      RD_MID_P1:   rd_addr = mid_p1;
      RD_IDX_P2:   rd_addr = idx_p2[PW-1:0];
      default:     rd_addr = '0;
    endcase
  end
  assign rd_en = cmd.rd_en;

  // Write address and data selection.
  always_comb begin
    unique case (cmd.wr_sel)
      WR_UP_DATA: begin
        wr_addr = idx_p1[PW-1:0];
        wr_data = rd_data;
      end
      WR_UP_KEY: begin
        wr_addr = idx_p1[PW-1:0];
        wr_data = key;
      end
      WR_AT_DATA: begin
        wr_addr = idx[PW-1:0];
        wr_data = rd_data;
      end
      default: begin
        wr_addr = '0;
        wr_data = key;
      end
    endcase
  end
  assign wr_en = cmd.wr_en;

  sat_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Request registers, loaded when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func <= in_func;
      key  <= in_key;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // Binary search bounds and probe point.
  always_ff @(posedge clk) begin
    if (cmd.bs_init) begin
      lo <= '0;
      hi <= cnt_m1;
    end else if (cmd.bs_lo) begin
      lo <= mid_s + IW'(1);
    end else if (cmd.bs_hi) begin
      hi <= mid_s - IW'(1);
    end
    if (cmd.mid_load) begin
      mid <= mid_calc;
    end
  end

  // Shift index.
  always_ff @(posedge clk) begin
    unique case (cmd.idx_op)
      IDX_HOLD:   idx <= idx;
      IDX_CNT_M1: idx <= cnt_m1;
      IDX_DEC:    idx <= idx_m1;
      IDX_INC:    idx <= idx_p1;
      IDX_MID:    idx <= mid_s;
      default:    idx <= idx;
    endcase
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_pos_sel)
        POS_ZERO:   res_pos <= '0;
        POS_IDX_P1: res_pos <= idx_p1[PW-1:0];
        POS_MID:    res_pos <= mid;
        default:    res_pos <= '0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_status   <= res_status;
      m_position <= res_pos;
      m_count    <= count;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.func       = func;
    stat.full       = (count == CW'(TABLE_DEPTH));
    stat.key_lt     = ($signed(key) < $signed(rd_data));
    stat.key_eq     = (key == rd_data);
    stat.idx_zero   = (idx == '0);
    stat.lo_gt_hi   = (lo > hi);
    stat.mid_last   = ((CW'(mid) + CW'(1)) >= count);
    stat.shift_last = (idx_p2 >= cnt_s);
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

/* design/sat_ctrl.sv */
// Controller state machine of the sorted array table.
// Sequences insert shifts, binary search probes and remove shifts. Uses sat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sat_ctrl
  import sat_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_INS_CMP  = 4'd2;
  localparam logic [3:0] S_INS_PUT  = 4'd3;
  localparam logic [3:0] S_BS_PROBE = 4'd4;
  localparam logic [3:0] S_BS_CMP   = 4'd5;
  localparam logic [3:0] S_RM_SHIFT = 4'd6;
  localparam logic [3:0] S_RM_END   = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.bs_init = 1'b1;
        if (stat.func == OP_INSERT) begin
          if (stat.full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_FULL;
            cmd.res_pos_sel = POS_ZERO;
            state_next     = S_FIN;
          end else begin
            // Start from the last entry; an empty table goes straight to the store.
            cmd.idx_op = IDX_CNT_M1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CNT_M1;
            state_next = S_INS_CMP;
          end
        end else if (stat.func == OP_REMOVE || stat.func == OP_SEARCH) begin
          state_next = S_BS_PROBE;
        end else begin
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_MISSING;
          cmd.res_pos_sel = POS_ZERO;
          state_next      = S_FIN;
        end
      end
      S_INS_CMP: begin
        // Read data holds table[idx]; a negative index means nothing is left.
        if (stat.idx_zero && !stat.key_lt) begin
          state_next = S_INS_PUT;
        end else if (stat.key_lt && !stat.lo_gt_hi) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_UP_DATA;
          cmd.idx_op = IDX_DEC;
          if (stat.idx_zero) begin
            state_next = S_INS_PUT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX_M1;
          end
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = WR_UP_KEY;
        cmd.cnt_inc     = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_status  = ST_OK;
        cmd.res_pos_sel = POS_IDX_P1;
        state_next      = S_FIN;
      end
      S_BS_PROBE: begin
        if (stat.lo_gt_hi) begin
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_MISSING;
          cmd.res_pos_sel = POS_ZERO;
          state_next      = S_FIN;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = RD_MID_CALC;
          cmd.mid_load = 1'b1;
          state_next   = S_BS_CMP;
        end
      end
      S_BS_CMP: begin
        if (stat.key_eq) begin
          if (stat.func == OP_SEARCH) begin
            cmd.res_load    = 1'b1;
            cmd.res_status  = ST_OK;
            cmd.res_pos_sel = POS_MID;
            state_next      = S_FIN;
          end else begin
            cmd.idx_op = IDX_MID;
            if (stat.mid_last) begin
              state_next = S_RM_END;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_MID_P1;
              state_next = S_RM_SHIFT;
            end
          end
        end else if (stat.key_lt) begin
          cmd.bs_hi  = 1'b1;
          state_next = S_BS_PROBE;
        end else begin
          cmd.bs_lo  = 1'b1;
          state_next = S_BS_PROBE;
        end
      end
      S_RM_SHIFT: begin
        // Read data holds table[idx+1]; move it down one place.
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_AT_DATA;
        cmd.idx_op = IDX_INC;
        if (stat.shift_last) begin
          state_next = S_RM_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P2;
        end
      end
      S_RM_END: begin
        cmd.cnt_dec     = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_status  = ST_OK;
        cmd.res_pos_sel = POS_MID;
        state_next      = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/sorted_array_table_unit.sv */
// Sorted array table unit: one result transaction per request transaction.
// An insert moves the larger entries up one place, a remove moves the entries above the
// match down one place; a full insert or an unused code is answered without a search. A
// search or remove makes at most log2(TABLE_DEPTH) + 1 probes. One request at a time: a
// new request is taken only after the result is pushed, so result stalls hold it off.
// Synchronous reset empties the table; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_table_unit
  import sat_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_WIDTH   = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  // Request channel.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [((KEY_WIDTH+7)/8)*8-1:0]    s_tdata,  // key
  input  wire logic [1:0]                        s_tuser,  // func
  // Result channel.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: position, used_count, zero fill
  output logic [(($clog2(TABLE_DEPTH)+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] m_tdata,
  output logic [1:0]                             m_tuser   // status
);

  localparam int PW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int ODW = ((PW + CW + 7) / 8) * 8;

  cmd_t          cmd;
  stat_t         stat;
  logic [PW-1:0] position;
  logic [CW-1:0] used_count;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_tuser),
    .in_key     (s_tdata[KEY_WIDTH-1:0]),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_status   (m_tuser),
    .m_position (position),
    .m_count    (used_count)
  );

  // Pack the result fields, position in the lowest bits.
  assign m_tdata = ODW'({used_count, position});

endmodule

`default_nettype wire
